### hdl/qtts_pkg.sv
// shared constants, command codes and controller/datapath structs
package qtts_pkg;

	localparam int ENTRIES_DEF   = 10;
	localparam int FIELD_LEN_DEF = 20;

	localparam logic [7:0] CH_ESC = 8'h23;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_EQ  = 8'h3D;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_TMPL  = 2'd2;

	typedef struct packed {
		logic clear;
		logic qbyte;
		logic esc_set;
		logic key_wr;
		logic key_done;
		logic emit_in;
		logic ent_start;
		logic ent_next;
		logic k_clr;
		logic k_inc;
		logic emit_val;
	} qtts_cmd_t;

	typedef struct packed {
		logic esc_open;
		logic key_zero;
		logic is_hash;
		logic len_eq;
		logic last_ent;
		logic byte_eq;
		logic k_end_key;
		logic vlen_zero;
		logic k_end_val;
		logic out_free;
	} qtts_stat_t;

endpackage

### hdl/qtts_ram.sv
// generic simple dual-port ram with registered read
module qtts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/qtts_dp.sv
// datapath: table storage, key buffer, search counters and output register
module qtts_dp #(
	parameter int ENTRIES   = qtts_pkg::ENTRIES_DEF,
	parameter int FIELD_LEN = qtts_pkg::FIELD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  qtts_pkg::qtts_cmd_t c,
	output qtts_pkg::qtts_stat_t st,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);
	import qtts_pkg::*;

	localparam int MC    = FIELD_LEN - 1;
	localparam int DEPTH = ENTRIES * MC;
	localparam int EW    = $clog2(ENTRIES + 1);
	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LW    = $clog2(FIELD_LEN);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = $clog2(DEPTH + 1);
	localparam int KAW   = (MC > 1) ? $clog2(MC) : 1;

	logic [EW-1:0] entry_q;
	logic          inval_q;
	logic          esc_q;
	logic [LW-1:0] klen_q;
	logic [BW-1:0] wbase_q;
	logic [LW-1:0] cur_nlen_q;
	logic [LW-1:0] cur_vlen_q;
	logic [LW-1:0] nlen_q [ENTRIES];
	logic [LW-1:0] vlen_q [ENTRIES];
	logic [IW-1:0] i_q;
	logic [BW-1:0] sbase_q;
	logic [LW-1:0] k_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	logic          q_live, q_amp, q_eq, n_we, v_we, k_we;
	logic [BW:0]   n_wsum, v_wsum, r_sum;
	logic [7:0]    n_rdata, v_rdata, k_rdata;
	logic [LW:0]   k_next;

	assign q_live = c.qbyte && (entry_q < EW'(ENTRIES));
	assign q_amp  = (data_byte == CH_AMP);
	assign q_eq   = (data_byte == CH_EQ);
	assign n_we   = q_live && !q_amp && !q_eq && !inval_q && (cur_nlen_q < LW'(MC));
	assign v_we   = q_live && !q_amp && !q_eq && inval_q && (cur_vlen_q < LW'(MC));
	assign k_we   = c.key_wr && (klen_q < LW'(MC));
	assign n_wsum = {1'b0, wbase_q} + (BW+1)'(cur_nlen_q);
	assign v_wsum = {1'b0, wbase_q} + (BW+1)'(cur_vlen_q);
	assign r_sum  = {1'b0, sbase_q} + (BW+1)'(k_q);
	assign k_next = {1'b0, k_q} + (LW+1)'(1);

	qtts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_name (
		.clk(clk), .we(n_we), .waddr(n_wsum[AW-1:0]), .wdata(data_byte),
		.raddr(r_sum[AW-1:0]), .rdata(n_rdata)
	);
	qtts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_value (
		.clk(clk), .we(v_we), .waddr(v_wsum[AW-1:0]), .wdata(data_byte),
		.raddr(r_sum[AW-1:0]), .rdata(v_rdata)
	);
	qtts_ram #(.WIDTH(8), .DEPTH(MC)) u_key (
		.clk(clk), .we(k_we), .waddr(klen_q[KAW-1:0]), .wdata(data_byte),
		.raddr(k_q[KAW-1:0]), .rdata(k_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q    <= '0;
			inval_q    <= 1'b0;
			esc_q      <= 1'b0;
			klen_q     <= '0;
			wbase_q    <= '0;
			cur_nlen_q <= '0;
			cur_vlen_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				nlen_q[j] <= '0;
				vlen_q[j] <= '0;
			end
		end else if (c.clear) begin
			entry_q    <= '0;
			inval_q    <= 1'b0;
			esc_q      <= 1'b0;
			klen_q     <= '0;
			wbase_q    <= '0;
			cur_nlen_q <= '0;
			cur_vlen_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				nlen_q[j] <= '0;
				vlen_q[j] <= '0;
			end
		end else begin
			if (q_live) begin
				if (q_amp) begin
					entry_q    <= entry_q + EW'(1);
					inval_q    <= 1'b0;
					wbase_q    <= wbase_q + BW'(MC);
					cur_nlen_q <= '0;
					cur_vlen_q <= '0;
				end else if (q_eq) begin
					inval_q                   <= 1'b1;
					cur_vlen_q                <= '0;
					vlen_q[entry_q[IW-1:0]]   <= '0;
				end else if (v_we) begin
					cur_vlen_q              <= cur_vlen_q + LW'(1);
					vlen_q[entry_q[IW-1:0]] <= cur_vlen_q + LW'(1);
				end else if (n_we) begin
					cur_nlen_q              <= cur_nlen_q + LW'(1);
					nlen_q[entry_q[IW-1:0]] <= cur_nlen_q + LW'(1);
				end
			end
			if (c.esc_set) begin
				esc_q <= 1'b1;
			end
			if (k_we) begin
				klen_q <= klen_q + LW'(1);
			end
			if (c.key_done) begin
				klen_q <= '0;
				esc_q  <= 1'b0;
			end
		end
	end

	// search walk over entries and characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			sbase_q <= '0;
			k_q     <= '0;
		end else begin
			if (c.ent_start) begin
				i_q     <= '0;
				sbase_q <= '0;
			end else if (c.ent_next) begin
				i_q     <= i_q + IW'(1);
				sbase_q <= sbase_q + BW'(MC);
			end
			if (c.k_clr) begin
				k_q <= '0;
			end else if (c.k_inc) begin
				k_q <= k_next[LW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c.emit_in || c.emit_val) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.emit_in) begin
			out_byte_q <= data_byte;
			out_last_q <= 1'b1;
		end else if (c.emit_val) begin
			out_byte_q <= v_rdata;
			out_last_q <= st.k_end_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		st.esc_open  = esc_q;
		st.key_zero  = (klen_q == '0);
		st.is_hash   = (data_byte == CH_ESC);
		st.len_eq    = (nlen_q[i_q] == klen_q);
		st.last_ent  = (i_q == IW'(ENTRIES - 1));
		st.byte_eq   = (n_rdata == k_rdata);
		st.k_end_key = (k_next == {1'b0, klen_q});
		st.vlen_zero = (vlen_q[i_q] == '0);
		st.k_end_val = (k_next == {1'b0, vlen_q[i_q]});
		st.out_free  = !out_valid_q || m_tready;
	end

	a_klen_max: assert property (@(posedge clk) disable iff (!arst_n)
		klen_q <= LW'(MC)) else $error("key length beyond field");
	a_entry_max: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q <= EW'(ENTRIES)) else $error("entry index beyond table");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(c.emit_in || c.emit_val) |-> st.out_free) else $error("output overwritten");

endmodule

### hdl/qtts_ctrl.sv
// controller: beat decode and the key search / value emission sequencer
module qtts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic [1:0]           cmd,
	output logic                 s_tready,
	input  qtts_pkg::qtts_stat_t st,
	output qtts_pkg::qtts_cmd_t  c
);
	import qtts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ENT  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_VRD  = 3'd4;
	localparam logic [2:0] S_VOUT = 3'd5;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign s_tready = (state_q == S_IDLE) && st.out_free;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		c       = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_CLEAR: c.clear = 1'b1;
						CMD_QUERY: c.qbyte = 1'b1;
						CMD_TMPL: begin
							if (st.is_hash) begin
								if (!st.esc_open) begin
									c.esc_set = 1'b1;
								end else if (st.key_zero) begin
									c.emit_in  = 1'b1;
									c.key_done = 1'b1;
								end else begin
									c.ent_start = 1'b1;
									state_d     = S_ENT;
								end
							end else if (st.esc_open) begin
								c.key_wr = 1'b1;
							end else begin
								c.emit_in = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_ENT: begin
				if (st.len_eq) begin
					c.k_clr = 1'b1;
					state_d = S_RD;
				end else if (st.last_ent) begin
					c.key_done = 1'b1;
					state_d    = S_IDLE;
				end else begin
					c.ent_next = 1'b1;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (!st.byte_eq) begin
					if (st.last_ent) begin
						c.key_done = 1'b1;
						state_d    = S_IDLE;
					end else begin
						c.ent_next = 1'b1;
						state_d    = S_ENT;
					end
				end else if (st.k_end_key) begin
					c.k_clr = 1'b1;
					if (st.vlen_zero) begin
						c.key_done = 1'b1;
						state_d    = S_IDLE;
					end else begin
						state_d = S_VRD;
					end
				end else begin
					c.k_inc = 1'b1;
					state_d = S_RD;
				end
			end
			S_VRD: state_d = S_VOUT;
			S_VOUT: begin
				if (st.out_free) begin
					c.emit_val = 1'b1;
					if (st.k_end_val) begin
						c.key_done = 1'b1;
						state_d    = S_IDLE;
					end else begin
						c.k_inc = 1'b1;
						state_d = S_VRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("beat taken during search");
	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		c.ent_start |=> (state_q == S_ENT)) else $error("search not started");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(c.key_done && state_q != S_IDLE) |=> (state_q == S_IDLE))
		else $error("search did not finish");

endmodule

### hdl/query_table_template_substitution.sv
// top level: query table with template substitution
// A beat on the slave side carries one byte and a command in tuser: clear the table, add a
// query byte, or expand a template byte. Clear, query bytes, plain template bytes, "##" and
// key characters are each handled when their beat is taken. A closing '#' of "#key#" starts
// a search run by the controller over the name memory: a length check per table entry, a
// registered memory read and then a compare per compared key character, then a read and an
// output step per emitted value byte, which waits while the output register is full.
// No beat is taken during a search. Results leave through a one-beat output register with
// tlast marking the final byte caused by the input beat; a new beat is taken while the
// register empties. Length tables are flip-flops, so clear resets them all at once.
module query_table_template_substitution #(
	parameter int ENTRIES   = qtts_pkg::ENTRIES_DEF,
	parameter int FIELD_LEN = qtts_pkg::FIELD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [1:0] s_tuser,  // [1:0] cmd
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast
);
	import qtts_pkg::*;

	qtts_cmd_t  cmd_w;
	qtts_stat_t stat_w;

	qtts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .cmd(s_tuser),
		.s_tready(s_tready), .st(stat_w), .c(cmd_w)
	);

	qtts_dp #(.ENTRIES(ENTRIES), .FIELD_LEN(FIELD_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(s_tdata), .c(cmd_w), .st(stat_w),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule
